// ----- src/vcm_pkg.sv -----
// Package for the vector clock merge table: widths, mode codes and the
// control/status structs between controller and datapath. No dependencies.
`default_nettype none

package vcm_pkg;

  // Default table geometry
  localparam int unsigned DEPTH_DEF    = 16;
  localparam int unsigned GID_BITS_DEF = 8;

  // Fixed field widths
  localparam int unsigned GID_PORT_W = 8;
  localparam int unsigned TIME_W     = 63;
  localparam int unsigned CMP_W      = 64;

  // Operation codes
  localparam logic [1:0] MODE_MERGE   = 2'd0;
  localparam logic [1:0] MODE_COMPARE = 2'd1;
  localparam logic [1:0] MODE_DUMP    = 2'd2;
  localparam logic [1:0] MODE_CLEAR   = 2'd3;

  // Controller to datapath commands
  typedef struct packed {
    logic latch;  // capture the accepted item
    logic clear;  // empty the table
    logic look;   // parallel id compare in all cells
    logic read;   // read the matched cell's time
    logic exec;   // update table (merge) and emit one result
    logic dump;   // emit the cell at the dump pointer
  } vcm_cmd_t;

  // Datapath to controller status
  typedef struct packed {
    logic empty;      // no valid entries
    logic dump_last;  // dump pointer is on the final entry
  } vcm_stat_t;

endpackage

`default_nettype wire

// ----- src/vcm_datapath.sv -----
// Datapath of the vector clock merge table: the sorted cell row, lookup,
// insert, compare and the result register. Depends on vcm_pkg.
`default_nettype none

module vcm_datapath import vcm_pkg::*; #(
  parameter int unsigned DEPTH    = DEPTH_DEF,
  parameter int unsigned GID_BITS = GID_BITS_DEF
) (
  input  wire logic                    clk_i,
  input  wire logic                    rst_ni,
  input  wire vcm_cmd_t                cmd_i,
  output vcm_stat_t                    stat_o,
  input  wire logic [1:0]              mode_i,
  input  wire logic [GID_PORT_W-1:0]   unit_gid_i,
  input  wire logic [TIME_W-1:0]       unit_time_i,
  input  wire logic                    other_present_i,
  output logic                         result_valid_o,
  output logic [GID_PORT_W-1:0]        out_gid_o,
  output logic [TIME_W-1:0]            out_time_o,
  output logic                         found_o,
  output logic signed [CMP_W-1:0]      cmp_value_o,
  output logic                         table_full_o,
  output logic                         last_o
);

  localparam int unsigned CW = $clog2(DEPTH + 1);
  localparam int unsigned IW = (DEPTH > 1) ? $clog2(DEPTH) : 1;
  localparam int unsigned PW = (GID_BITS < GID_PORT_W) ? GID_BITS : GID_PORT_W;

  // Cell row (contents undefined until written)
  logic [GID_BITS-1:0] cell_gid_q  [DEPTH];
  logic [TIME_W-1:0]   cell_time_q [DEPTH];
  logic [CW-1:0]       count_q;

  // Latched item
  logic [1:0]          mode_q;
  logic [GID_BITS-1:0] gid_q;
  logic [TIME_W-1:0]   time_q;
  logic                oth_q;

  // Lookup results
  logic                found_q;
  logic [IW-1:0]       idx_q;
  logic [DEPTH-1:0]    ins_q;
  logic [DEPTH-1:0]    shin_q;
  logic [TIME_W-1:0]   rd_time_q;
  logic [IW-1:0]       dptr_q;

  logic [GID_BITS-1:0] gid_in;
  logic [DEPTH-1:0]    valid;
  logic [DEPTH-1:0]    match;
  logic [DEPTH-1:0]    gt;
  logic [DEPTH-1:0]    ins_d;
  logic [DEPTH-1:0]    shin_d;
  logic [IW-1:0]       idx_d;
  logic                full;
  logic [TIME_W-1:0]   max_time;
  logic [CMP_W-1:0]    diff;
  logic [CMP_W-1:0]    cmp_d;
  logic [GID_PORT_W-1:0] gid_out;
  logic [GID_PORT_W-1:0] dump_gid_out;

  // Id width adaptation between the port and the cells
  always_comb begin
    gid_in       = '0;
    gid_out      = '0;
    dump_gid_out = '0;
    for (int b = 0; b < PW; b++) begin
      gid_in[b]       = unit_gid_i[b];
      gid_out[b]      = gid_q[b];
      dump_gid_out[b] = cell_gid_q[dptr_q][b];
    end
  end

  // Per-cell compare against the latched id
  always_comb begin
    idx_d = '0;
    for (int i = 0; i < DEPTH; i++) begin
      valid[i] = CW'(i) < count_q;
      match[i] = valid[i] && (cell_gid_q[i] == gid_q);
      gt[i]    = valid[i] && (cell_gid_q[i] > gid_q);
      ins_d[i] = valid[i] ? gt[i] : (CW'(i) == count_q);
      if (i > 0) begin
        shin_d[i] = gt[i-1];
      end else begin
        shin_d[i] = 1'b0;
      end
      if (match[i]) begin
        idx_d = idx_d | IW'(i);
      end
    end
  end

  assign full     = (count_q == CW'(DEPTH));
  assign max_time = (time_q > rd_time_q) ? time_q : rd_time_q;
  assign diff     = {1'b0, rd_time_q} - {1'b0, time_q};

  // Compare result selection
  always_comb begin
    case ({found_q, oth_q})
      2'b11:   cmp_d = diff;
      2'b10:   cmp_d = CMP_W'(1);
      2'b01:   cmp_d = '1;
      default: cmp_d = '0;
    endcase
  end

  assign stat_o.empty     = (count_q == '0);
  assign stat_o.dump_last = ((CW'(dptr_q) + CW'(1)) == count_q);

  // Item capture, lookup and read registers
  always_ff @(posedge clk_i) begin
    if (cmd_i.latch) begin
      mode_q <= mode_i;
      gid_q  <= gid_in;
      time_q <= unit_time_i;
      oth_q  <= other_present_i;
    end
    if (cmd_i.look) begin
      found_q <= |match;
      idx_q   <= idx_d;
      ins_q   <= ins_d;
      shin_q  <= shin_d;
    end
    if (cmd_i.read) begin
      rd_time_q <= cell_time_q[idx_q];
    end
  end

  // Entry count and dump pointer
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      count_q <= '0;
      dptr_q  <= '0;
    end else begin
      if (cmd_i.clear) begin
        count_q <= '0;
      end else if (cmd_i.exec && mode_q == MODE_MERGE && !found_q && !full) begin
        count_q <= count_q + CW'(1);
      end
      if (cmd_i.latch) begin
        dptr_q <= '0;
      end else if (cmd_i.dump) begin
        dptr_q <= dptr_q + IW'(1);
      end
    end
  end

  // Cell updates: max on hit, shifting insert on miss
  always_ff @(posedge clk_i) begin
    if (cmd_i.exec && mode_q == MODE_MERGE) begin
      if (found_q) begin
        cell_time_q[idx_q] <= max_time;
      end else if (!full) begin
        for (int i = 0; i < DEPTH; i++) begin
          if (ins_q[i]) begin
            if (shin_q[i] && i > 0) begin
              cell_gid_q[i]  <= cell_gid_q[i-1];
              cell_time_q[i] <= cell_time_q[i-1];
            end else begin
              cell_gid_q[i]  <= gid_q;
              cell_time_q[i] <= time_q;
            end
          end
        end
      end
    end
  end

  // Result strobe
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      result_valid_o <= 1'b0;
    end else begin
      result_valid_o <= cmd_i.exec || cmd_i.dump;
    end
  end

  // Result payload
  always_ff @(posedge clk_i) begin
    if (cmd_i.dump) begin
      out_gid_o    <= dump_gid_out;
      out_time_o   <= cell_time_q[dptr_q];
      found_o      <= 1'b1;
      cmp_value_o  <= '0;
      table_full_o <= 1'b0;
      last_o       <= stat_o.dump_last;
    end else if (cmd_i.exec) begin
      out_gid_o <= gid_out;
      found_o   <= found_q;
      last_o    <= 1'b1;
      if (mode_q == MODE_MERGE) begin
        cmp_value_o  <= '0;
        table_full_o <= !found_q && full;
        if (found_q) begin
          out_time_o <= max_time;
        end else if (full) begin
          out_time_o <= '0;
        end else begin
          out_time_o <= time_q;
        end
      end else begin
        cmp_value_o  <= cmp_d;
        table_full_o <= 1'b0;
        out_time_o   <= found_q ? rd_time_q : '0;
      end
    end
  end

endmodule

`default_nettype wire

// ----- src/vcm_ctrl.sv -----
// Controller of the vector clock merge table: sequences clear, lookup, read,
// execute and dump steps. Depends on vcm_pkg.
`default_nettype none

module vcm_ctrl import vcm_pkg::*; (
  input  wire logic       clk_i,
  input  wire logic       rst_ni,
  input  wire logic       start,
  output logic            busy,
  input  wire logic [1:0] mode_i,
  input  wire vcm_stat_t  stat_i,
  output vcm_cmd_t        cmd_o
);

  typedef enum logic [2:0] {
    S_IDLE,
    S_LOOK,
    S_READ,
    S_EXEC,
    S_DUMP
  } state_e;

  state_e state_q, state_d;
  logic   accept;

  assign busy   = (state_q != S_IDLE);
  assign accept = start && !busy;

  // Next state and command decode
  always_comb begin
    state_d = state_q;
    cmd_o   = '0;
    unique case (state_q)
      S_IDLE: begin
        if (accept) begin
          cmd_o.latch = 1'b1;
          case (mode_i)
            MODE_CLEAR: cmd_o.clear = 1'b1;
            MODE_DUMP:  state_d = stat_i.empty ? S_IDLE : S_DUMP;
            default:    state_d = S_LOOK;
          endcase
        end
      end
      S_LOOK: begin
        cmd_o.look = 1'b1;
        state_d    = S_READ;
      end
      S_READ: begin
        cmd_o.read = 1'b1;
        state_d    = S_EXEC;
      end
      S_EXEC: begin
        cmd_o.exec = 1'b1;
        state_d    = S_IDLE;
      end
      S_DUMP: begin
        cmd_o.dump = 1'b1;
        if (stat_i.dump_last) begin
          state_d = S_IDLE;
        end
      end
      default: state_d = S_IDLE;
    endcase
  end

  // State register
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= S_IDLE;
    end else begin
      state_q <= state_d;
    end
  end

endmodule

`default_nettype wire

// ----- src/vector_clock_merge_table_core.sv -----
// Merge or compare: the item is latched on acceptance, then the lookup, cell read
// and execute steps run in turn and the result strobe is registered from the
// execute step; no new command is taken until these steps are through. Dump of
// N entries: one transfer per cycle, busy until the final entry has been sent.
// Clear, or dump of an empty table: no result, busy stays low.
// Reset (rst_ni low, async) empties the table; cell contents are kept undefined.
// The receiver cannot stall: result_valid_o is high for a single cycle per result.
`default_nettype none

module vector_clock_merge_table_core import vcm_pkg::*; #(
  parameter int unsigned DEPTH    = DEPTH_DEF,
  parameter int unsigned GID_BITS = GID_BITS_DEF
) (
  input  wire logic                  clk_i,
  input  wire logic                  rst_ni,
  input  wire logic                  start,
  output logic                       busy,
  input  wire logic [1:0]            mode_i,
  input  wire logic [GID_PORT_W-1:0] unit_gid_i,
  input  wire logic [TIME_W-1:0]     unit_time_i,
  input  wire logic                  other_present_i,
  output logic                       result_valid_o,
  output logic [GID_PORT_W-1:0]      out_gid_o,
  output logic [TIME_W-1:0]          out_time_o,
  output logic                       found_o,
  output logic signed [CMP_W-1:0]    cmp_value_o,
  output logic                       table_full_o,
  output logic                       last_o
);

  vcm_cmd_t  cmd;
  vcm_stat_t stat;

  // Sequencer
  vcm_ctrl u_ctrl (
    .clk_i  (clk_i),
    .rst_ni (rst_ni),
    .start  (start),
    .busy   (busy),
    .mode_i (mode_i),
    .stat_i (stat),
    .cmd_o  (cmd)
  );

  // Table and result datapath
  vcm_datapath #(
    .DEPTH    (DEPTH),
    .GID_BITS (GID_BITS)
  ) u_datapath (
    .clk_i           (clk_i),
    .rst_ni          (rst_ni),
    .cmd_i           (cmd),
    .stat_o          (stat),
    .mode_i          (mode_i),
    .unit_gid_i      (unit_gid_i),
    .unit_time_i     (unit_time_i),
    .other_present_i (other_present_i),
    .result_valid_o  (result_valid_o),
    .out_gid_o       (out_gid_o),
    .out_time_o      (out_time_o),
    .found_o         (found_o),
    .cmp_value_o     (cmp_value_o),
    .table_full_o    (table_full_o),
    .last_o          (last_o)
  );

endmodule

`default_nettype wire
